// File: rtl/component_health_tracker_top_defines.svh
// assertion macros for the component health tracker checker
// no dependencies; included by files that hold concurrent assertions
`ifndef COMPONENT_HEALTH_TRACKER_TOP_DEFINES_SVH
`define COMPONENT_HEALTH_TRACKER_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is applied
`define CHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define CHT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cht_pkg.sv
// shared types, codes and helpers of the component health tracker
// no dependencies; imported by the controller, the datapath and the top level
package cht_pkg;

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // most plans one scan may emit
  localparam int MAX_RESULTS = 16;

  // request codes
  localparam logic [2:0] REQ_OBSERVE = 3'd0;
  localparam logic [2:0] REQ_ISOLATE = 3'd1;
  localparam logic [2:0] REQ_RECOVER = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_SCAN    = 3'd4;

  // condition codes
  localparam logic [1:0] COND_HEALTHY    = 2'd0;
  localparam logic [1:0] COND_DEGRADED   = 2'd1;
  localparam logic [1:0] COND_ISOLATED   = 2'd2;
  localparam logic [1:0] COND_RECOVERING = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_INITIAL_LEVEL  = 3'd0;
  localparam logic [2:0] CFG_SAMPLE_WEIGHT  = 3'd1;
  localparam logic [2:0] CFG_HEALTHY_LEVEL  = 3'd2;
  localparam logic [2:0] CFG_DEGRADED_LEVEL = 3'd3;

  // configuration reset values
  localparam logic [15:0] RST_INITIAL_LEVEL  = 16'd32768;
  localparam logic [15:0] RST_SAMPLE_WEIGHT  = 16'd11469;
  localparam logic [15:0] RST_HEALTHY_LEVEL  = 16'd24576;
  localparam logic [15:0] RST_DEGRADED_LEVEL = 16'd11469;

  typedef struct packed {
    logic [15:0] health;
    logic [1:0]  cond;
    logic [15:0] fail;
    logic [15:0] rec;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  idx;
    logic [15:0] health;
    logic [1:0]  cond;
    logic [15:0] fail;
    logic [15:0] rec;
    logic [15:0] shortfall;
    logic        action;
    logic        last;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic mul1;
    logic mul2;
    logic point_wr;
    logic scan_flush;
  } cmd_t;

  typedef struct packed {
    logic observe_hit;
    logic scan_done;
  } status_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_RD       = 8'b0000_0010,
    ST_MUL1     = 8'b0000_0100,
    ST_MUL2     = 8'b0000_1000,
    ST_WR       = 8'b0001_0000,
    ST_SCAN     = 8'b0010_0000,
    ST_SCAN_END = 8'b0100_0000,
    ST_FLUSH    = 8'b1000_0000
  } state_t;

  function automatic logic [15:0] sat_one(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/cht_ctrl.sv
// sequencer of the component health tracker
// depends on cht_pkg; drives the datapath through cmd_t and reads status_t
module cht_ctrl import cht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_req_type,
  input  status_t    st,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_req_type == REQ_SCAN) ? ST_SCAN : ST_RD;
        end
      end
      ST_RD:       state_nxt = st.observe_hit ? ST_MUL1 : ST_WR;
      ST_MUL1:     state_nxt = ST_MUL2;
      ST_MUL2:     state_nxt = ST_WR;
      ST_WR:       state_nxt = ST_IDLE;
      ST_SCAN:     state_nxt = st.scan_done ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END: state_nxt = ST_FLUSH;
      ST_FLUSH:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.load       = (state_r == ST_IDLE) && start;
    cmd.scan_rd    = (state_r == ST_SCAN);
    cmd.mul1       = (state_r == ST_MUL1);
    cmd.mul2       = (state_r == ST_MUL2);
    cmd.point_wr   = (state_r == ST_WR);
    cmd.scan_flush = (state_r == ST_FLUSH);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/cht_dp.sv
// datapath of the component health tracker: config registers, entry memory,
// ewma multiplier, scan plan buffer and result register; depends on cht_pkg
module cht_dp import cht_pkg::*; #(
  parameter int NUM_COMPONENTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [2:0]         in_req_type,
  input  logic [3:0]         in_component_id,
  input  logic signed [16:0] in_level,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               res_strobe,
  output result_t            res
);

  localparam int AW    = $clog2(NUM_COMPONENTS);
  localparam int ACC_W = 31;
  localparam int PW    = $clog2(MAX_RESULTS + 1);

  // configuration
  logic [15:0] initial_level_r, sample_weight_r, healthy_level_r, degraded_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_level_r  <= RST_INITIAL_LEVEL;
      sample_weight_r  <= RST_SAMPLE_WEIGHT;
      healthy_level_r  <= RST_HEALTHY_LEVEL;
      degraded_level_r <= RST_DEGRADED_LEVEL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INITIAL_LEVEL:  initial_level_r  <= cfg_wdata;
        CFG_SAMPLE_WEIGHT:  sample_weight_r  <= cfg_wdata;
        CFG_HEALTHY_LEVEL:  healthy_level_r  <= cfg_wdata;
        CFG_DEGRADED_LEVEL: degraded_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured request
  logic [2:0]  req_r;
  logic [3:0]  id_r;
  logic [15:0] lvl_r;
  logic [15:0] lvl_clamped;

  always_comb begin
    if (in_level[16]) begin
      lvl_clamped = 16'd0;
    end else begin
      lvl_clamped = sat_one(in_level[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      id_r  <= in_component_id;
      lvl_r <= lvl_clamped;
    end
  end

  logic          inrange;
  logic [AW-1:0] id_addr;
  assign inrange = (7'(id_r) < 7'(NUM_COMPONENTS));
  assign id_addr = AW'(id_r);

  // scan counter
  logic [AW-1:0] scan_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_cnt_r <= scan_cnt_r + AW'(1);
    end
  end

  // entry memory and valid bits
  entry_t                    mem [NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] valid_r;
  logic [AW-1:0]             rd_addr;
  entry_t                    rd_data_r;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_idx_r;
  logic                      rd_live_r;
  logic                      wr_en;
  logic                      set_valid;
  entry_t                    wr_data;

  assign rd_addr = cmd.scan_rd ? scan_cnt_r : id_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[id_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
    rd_vld_r  <= (7'(rd_addr) < 7'(NUM_COMPONENTS)) ? valid_r[rd_addr] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_live_r <= 1'b0;
    end else begin
      rd_live_r <= cmd.scan_rd;
      if (set_valid) begin
        valid_r[id_addr] <= 1'b1;
      end
    end
  end

  // record as seen by a point request; a missing entry reads as a fresh one
  entry_t cur;
  logic   present;
  always_comb begin
    if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur.health = sat_one(initial_level_r);
      cur.cond   = COND_HEALTHY;
      cur.fail   = 16'd0;
      cur.rec    = 16'd0;
    end
  end
  assign present = inrange && rd_vld_r;

  // ewma in two multiply steps (mul1, mul2), one multiplier each
  logic [15:0]      w_sat, w_old;
  logic [ACC_W-1:0] prod_r, acc_r;
  assign w_sat = sat_one(sample_weight_r);
  assign w_old = ONE_Q15 - w_sat;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_r <= ACC_W'(32'(cur.health) * 32'(w_old));
    end
    if (cmd.mul2) begin
      acc_r <= prod_r + ACC_W'(32'(lvl_r) * 32'(w_sat));
    end
  end

  assign st.observe_hit = (req_r == REQ_OBSERVE) && inrange;
  assign st.scan_done   = (scan_cnt_r == AW'(NUM_COMPONENTS - 1));

  // point update
  logic [15:0] h_obs;
  logic [1:0]  cond_obs;
  result_t     point_res;

  assign h_obs = acc_r[ACC_W-1:15];

  always_comb begin
    if (h_obs >= healthy_level_r) begin
      cond_obs = COND_HEALTHY;
    end else if (h_obs >= degraded_level_r) begin
      cond_obs = COND_DEGRADED;
    end else begin
      cond_obs = COND_ISOLATED;
    end
  end

  always_comb begin
    wr_en          = 1'b0;
    set_valid      = 1'b0;
    wr_data        = cur;
    point_res      = '0;
    point_res.idx  = id_r;
    point_res.last = 1'b1;
    if (st.observe_hit) begin
      wr_data.health = h_obs;
      wr_data.cond   = cond_obs;
      wr_data.fail   = (lvl_r < cur.health) ? sat_inc(cur.fail) : cur.fail;
      wr_en          = cmd.point_wr;
      set_valid      = cmd.point_wr;
    end else if (present) begin
      unique case (req_r)
        REQ_ISOLATE: begin
          wr_data.cond = COND_ISOLATED;
          wr_en        = cmd.point_wr;
        end
        REQ_RECOVER: begin
          wr_data.health = lvl_r;
          wr_data.cond   = (lvl_r >= healthy_level_r) ? COND_HEALTHY : COND_RECOVERING;
          wr_data.rec    = sat_inc(cur.rec);
          wr_en          = cmd.point_wr;
        end
        default: ;
      endcase
    end
    if (wr_en || (present && (req_r == REQ_QUERY))) begin
      point_res.found  = 1'b1;
      point_res.health = wr_data.health;
      point_res.cond   = wr_data.cond;
      point_res.fail   = wr_data.fail;
      point_res.rec    = wr_data.rec;
    end
  end

  // scan plans: hold one plan back so the final one can carry last_item;
  // only the first MAX_RESULTS plans of a scan are taken
  logic          scan_hit;
  result_t       scan_res;
  logic          pend_valid_r;
  result_t       pend_r;
  logic [PW-1:0] plan_cnt_r;

  assign scan_hit = rd_live_r && rd_vld_r && (rd_data_r.cond != COND_HEALTHY) &&
                    (plan_cnt_r < PW'(MAX_RESULTS));

  always_comb begin
    scan_res           = '0;
    scan_res.found     = 1'b1;
    scan_res.idx       = 4'(rd_idx_r);
    scan_res.health    = rd_data_r.health;
    scan_res.cond      = rd_data_r.cond;
    scan_res.fail      = rd_data_r.fail;
    scan_res.rec       = rd_data_r.rec;
    scan_res.shortfall = ONE_Q15 - sat_one(rd_data_r.health);
    scan_res.action    = (rd_data_r.cond == COND_ISOLATED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      pend_valid_r <= 1'b0;
      plan_cnt_r   <= '0;
    end else if (scan_hit) begin
      pend_valid_r <= 1'b1;
      plan_cnt_r   <= plan_cnt_r + PW'(1);
    end
    if (scan_hit) begin
      pend_r <= scan_res;
    end
  end

  // result register
  logic    res_strobe_r, res_strobe_nxt;
  result_t res_r, res_nxt;

  always_comb begin
    res_strobe_nxt = 1'b0;
    res_nxt        = point_res;
    if (cmd.point_wr) begin
      res_strobe_nxt = 1'b1;
    end else if (scan_hit && pend_valid_r) begin
      res_strobe_nxt = 1'b1;
      res_nxt        = pend_r;
      res_nxt.last   = 1'b0;
    end else if (cmd.scan_flush) begin
      res_strobe_nxt = 1'b1;
      if (pend_valid_r) begin
        res_nxt      = pend_r;
      end else begin
        res_nxt      = '0;
      end
      res_nxt.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_strobe_r <= 1'b0;
    end else begin
      res_strobe_r <= res_strobe_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_strobe = res_strobe_r;
  assign res        = res_r;

endmodule

// File: rtl/component_health_tracker_top.sv
// top level of the component health tracker
// depends on cht_pkg, cht_ctrl and cht_dp
//
//  channel   handshake                       payload
//  -------   -----------------------------   ------------------------------------
//  request   start & !busy                   in_req_type, in_component_id, in_level
//  result    out_strobe (one cycle, no hold) out_found .. out_last_item
//  config    cfg_valid & cfg_ready           cfg_index, cfg_wdata
//
// isolate, recover, query and unknown requests: busy in read and write states,
// result beat in the cycle after busy drops; observe on a table entry: busy in
// read, two multiply steps and write; scan: busy while the one read port of the
// entry memory walks every entry, then in scan end and flush; plans leave one per
// non-healthy entry, at most 16, the final one in the cycle after busy drops
// reset is synchronous, active low; it clears valid bits, config and control
// the receiver cannot stall: every result beat shows for exactly one cycle
// cfg_ready is low while busy, so register writes only land between requests
module component_health_tracker_top import cht_pkg::*; #(
  parameter int NUM_COMPONENTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic [3:0]         in_component_id,
  input  logic signed [16:0] in_level,
  // result channel
  output logic               out_strobe,
  output logic               out_found,
  output logic [3:0]         out_entry_index,
  output logic [15:0]        out_health_level,
  output logic [1:0]         out_condition,
  output logic [15:0]        out_failures_seen,
  output logic [15:0]        out_recoveries_done,
  output logic [15:0]        out_shortfall,
  output logic               out_plan_action,
  output logic               out_last_item,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  cmd_t    cmd;
  status_t st;
  result_t res;

  // controller: one-hot sequencer for point requests and the scan walk
  cht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .st          (st),
    .cmd         (cmd),
    .busy        (busy)
  );

  // datapath: config, entry table, ewma, plan buffer, result register
  cht_dp #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_req_type),
    .in_component_id (in_component_id),
    .in_level        (in_level),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .res_strobe      (out_strobe),
    .res             (res)
  );

  // config writes wait while a request is in flight
  assign cfg_ready = !busy;

  // unpack the result beat
  assign out_found           = res.found;
  assign out_entry_index     = res.idx;
  assign out_health_level    = res.health;
  assign out_condition       = res.cond;
  assign out_failures_seen   = res.fail;
  assign out_recoveries_done = res.rec;
  assign out_shortfall       = res.shortfall;
  assign out_plan_action     = res.action;
  assign out_last_item       = res.last;

endmodule

// File: rtl/cht_checker.sv
// port-level checker for the component health tracker, bound to the top level
// depends on cht_pkg and component_health_tracker_top_defines.svh
`include "component_health_tracker_top_defines.svh"

module cht_port_props import cht_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_found,
  input logic [15:0] out_health_level,
  input logic [1:0]  out_condition,
  input logic [15:0] out_shortfall,
  input logic        out_plan_action,
  input logic        out_last_item
);

  // an accepted request keeps the block busy in the next cycle
  `CHT_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept did not raise busy")

  // a miss or empty scan is a single final beat with a zero record
  `CHT_ASSERT(a_miss_shape, clk, rst_n, (out_strobe && !out_found) |-> (out_last_item && out_health_level == 16'd0 && out_shortfall == 16'd0 && !out_plan_action), "bad miss beat")

  // isolate-and-restore plans only for isolated entries
  `CHT_ASSERT(a_plan_isolated, clk, rst_n, (out_strobe && out_plan_action) |-> (out_condition == COND_ISOLATED), "plan action without isolation")

  // health never exceeds one in q1.15
  `CHT_ASSERT(a_health_range, clk, rst_n, (out_strobe && out_found) |-> (out_health_level <= ONE_Q15), "health above one")

  // reset leaves the block idle with no result beat
  `CHT_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> (!busy && !out_strobe), "activity after reset")

endmodule

bind component_health_tracker_top cht_port_props u_cht_checker (.*);
